// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define PSF_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("assertion failed");

// condition holds in the cycle after the trigger
`define PSF_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

// ----- rtl/psf_pkg.sv -----
// ----------------------------------------------------------------------------
// psf_pkg
// types and constants of the packet slot fifo
// ----------------------------------------------------------------------------
package psf_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int SLOT_BYTES_DEF = 64;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int FILL_W    = 5;
  localparam int STATUS_W  = 3;
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 24;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_POP_DATA = 3'd0,
    STAT_PUSHED   = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_TRUNC    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LEN    = 2'd1,
    S_STREAM = 2'd2
  } state_e;

endpackage

// ----- rtl/psf_ram.sv -----
// ----------------------------------------------------------------------------
// psf_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module psf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/packet_slot_fifo_unit.sv -----
// push: one byte item per cycle while tready is high; the result of the last byte is registered
// pop: the first byte passes length read, byte read and output register, then one byte per
//   cycle from the byte ram read port while not stalled; next item taken after the last byte
// empty pop and rejected push: one status result, shown in the cycle after the item
// reset clears pointers, counts and build state; byte and length rams are not cleared
// ----------------------------------------------------------------------------
// packet_slot_fifo_unit
// queue of whole packets held in a ring of fixed-size slots in block ram
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module packet_slot_fifo_unit #(
  parameter int CAPACITY   = psf_pkg::CAPACITY_DEF,
  parameter int SLOT_BYTES = psf_pkg::SLOT_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [psf_pkg::S_TDATA_W-1:0] s_axis_tdata,  // in_byte
  input  logic                          s_axis_tlast,  // in_last
  input  logic                          s_axis_tuser,  // mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_byte, packet_length, available, fill_count, zero pad
  output logic [psf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,  // out_last
  output logic [psf_pkg::STATUS_W-1:0]  m_axis_tuser   // status
);

  import psf_pkg::*;

  localparam int AW = $clog2(CAPACITY * SLOT_BYTES);
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = $clog2(SLOT_BYTES + 1);
  localparam logic [AW-1:0] LAST_BASE = AW'((CAPACITY - 1) * SLOT_BYTES);
  localparam logic [AW-1:0] SLOT_STEP = AW'(SLOT_BYTES);

  state_e            state_q, state_d;
  logic [IW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [AW-1:0]     head_base_q, head_base_d, tail_base_q, tail_base_d;
  logic [AW-1:0]     rd_base_q, rd_base_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [LW-1:0]     off_q, off_d, idx_q, idx_d, len_q, len_d;
  logic              ovf_q, ovf_d, rej_q, rej_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  logic              out_avail_q, out_avail_d;
  logic [FILL_W-1:0] out_fill_q, out_fill_d;

  logic              bw_en, br_en, lw_en, lr_en;
  logic [AW-1:0]     bw_addr, br_addr;
  logic [IW-1:0]     lr_addr;
  logic [BYTE_W-1:0] br_data;
  logic [LEN_W-1:0]  lr_data, len_clamp;

  logic              out_free, in_acc, rej_now, ovf_new;
  logic [LW-1:0]     off_new, idx_inc;
  logic [CW-1:0]     cnt_inc;

  psf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CAPACITY * SLOT_BYTES)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (bw_en),
    .waddr_i (bw_addr),
    .wdata_i (s_axis_tdata[BYTE_W-1:0]),
    .re_i    (br_en),
    .raddr_i (br_addr),
    .rdata_o (br_data)
  );

  psf_ram #(
    .WIDTH (LEN_W),
    .DEPTH (CAPACITY)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (lw_en),
    .waddr_i (tail_q),
    .wdata_i (LEN_W'(off_new)),
    .re_i    (lr_en),
    .raddr_i (lr_addr),
    .rdata_o (lr_data)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign rej_now = rej_q || ((off_q == '0) && !ovf_q && (cnt_q >= CW'(CAPACITY)));
  assign idx_inc = LW'(idx_q + LW'(1));
  assign cnt_inc = CW'(cnt_q + CW'(1));

  always_comb begin
    if (lr_data > LEN_W'(SLOT_BYTES)) begin
      len_clamp = LEN_W'(SLOT_BYTES);
    end else if (lr_data == '0) begin
      len_clamp = LEN_W'(1);
    end else begin
      len_clamp = lr_data;
    end
  end

  always_comb begin
    ovf_new = ovf_q;
    off_new = off_q;
    bw_en   = 1'b0;
    bw_addr = AW'(tail_base_q + AW'(off_q));
    if (in_acc && (s_axis_tuser == MODE_PUSH) && !rej_now) begin
      if (off_q < LW'(SLOT_BYTES)) begin
        bw_en   = 1'b1;
        off_new = LW'(off_q + LW'(1));
      end else begin
        ovf_new = 1'b1;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    head_base_d  = head_base_q;
    tail_base_d  = tail_base_q;
    rd_base_d    = rd_base_q;
    cnt_d        = cnt_q;
    off_d        = off_q;
    ovf_d        = ovf_q;
    rej_d        = rej_q;
    idx_d        = idx_q;
    len_d        = len_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_len_d    = out_len_q;
    out_avail_d  = out_avail_q;
    out_fill_d   = out_fill_q;
    br_en        = 1'b0;
    br_addr      = rd_base_q;
    lw_en        = 1'b0;
    lr_en        = 1'b0;
    lr_addr      = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (s_axis_tuser == MODE_PUSH)) begin
          if (s_axis_tlast) begin
            off_d       = '0;
            ovf_d       = 1'b0;
            rej_d       = 1'b0;
            out_valid_d = 1'b1;
            out_byte_d  = '0;
            out_last_d  = 1'b1;
            if (rej_now) begin
              out_status_d = STAT_FULL;
              out_len_d    = '0;
              out_avail_d  = (cnt_q != '0);
              out_fill_d   = FILL_W'(cnt_q);
            end else begin
              lw_en        = 1'b1;
              tail_d       = (tail_q == IW'(CAPACITY - 1)) ? '0 : IW'(tail_q + IW'(1));
              tail_base_d  = (tail_base_q == LAST_BASE) ? '0 : AW'(tail_base_q + SLOT_STEP);
              cnt_d        = cnt_inc;
              out_status_d = ovf_new ? STAT_TRUNC : STAT_PUSHED;
              out_len_d    = LEN_W'(off_new);
              out_avail_d  = 1'b1;
              out_fill_d   = FILL_W'(cnt_inc);
            end
          end else begin
            off_d = off_new;
            ovf_d = ovf_new;
            rej_d = rej_now;
          end
        end else if (in_acc) begin
          if (cnt_q == '0) begin
            out_valid_d  = 1'b1;
            out_status_d = STAT_EMPTY;
            out_byte_d   = '0;
            out_last_d   = 1'b1;
            out_len_d    = '0;
            out_avail_d  = 1'b0;
            out_fill_d   = '0;
          end else begin
            lr_en       = 1'b1;
            rd_base_d   = head_base_q;
            head_d      = (head_q == IW'(CAPACITY - 1)) ? '0 : IW'(head_q + IW'(1));
            head_base_d = (head_base_q == LAST_BASE) ? '0 : AW'(head_base_q + SLOT_STEP);
            cnt_d       = CW'(cnt_q - CW'(1));
            state_d     = S_LEN;
          end
        end
      end
      S_LEN: begin
        len_d   = LW'(len_clamp);
        idx_d   = '0;
        br_en   = 1'b1;
        br_addr = rd_base_q;
        state_d = S_STREAM;
      end
      S_STREAM: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_POP_DATA;
          out_byte_d   = br_data;
          out_last_d   = (idx_inc == len_q);
          out_len_d    = LEN_W'(len_q);
          out_avail_d  = (cnt_q != '0);
          out_fill_d   = FILL_W'(cnt_q);
          if (idx_inc == len_q) begin
            state_d = S_IDLE;
          end else begin
            br_en   = 1'b1;
            br_addr = AW'(rd_base_q + AW'(idx_inc));
            idx_d   = idx_inc;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      head_base_q <= '0;
      tail_base_q <= '0;
      cnt_q       <= '0;
      off_q       <= '0;
      ovf_q       <= 1'b0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      head_base_q <= head_base_d;
      tail_base_q <= tail_base_d;
      cnt_q       <= cnt_d;
      off_q       <= off_d;
      ovf_q       <= ovf_d;
      rej_q       <= rej_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_base_q    <= rd_base_d;
    idx_q        <= idx_d;
    len_q        <= len_d;
    out_status_q <= out_status_d;
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
    out_len_q    <= out_len_d;
    out_avail_q  <= out_avail_d;
    out_fill_q   <= out_fill_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, out_fill_q, out_avail_q, out_len_q, out_byte_q};

  `PSF_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CW'(CAPACITY))
  `PSF_ASSERT_SAME(a_ready_idle, s_axis_tready, state_q == S_IDLE)
  `PSF_ASSERT_NEXT(a_pop_reads_len,
    in_acc && (s_axis_tuser == MODE_POP) && (cnt_q != '0), state_q == S_LEN)
  `PSF_ASSERT_SAME(a_idx_in_len, state_q == S_STREAM, (idx_q < len_q) && (len_q != '0))

endmodule

// ----- dv/psf_scoreboard_pkg.sv -----
// ----------------------------------------------------------------------------
// psf_scoreboard_pkg
// result prediction and checking for the packet slot fifo
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package psf_scoreboard_pkg;

  import psf_pkg::*;

  localparam int RING_SLOTS = CAPACITY_DEF;
  localparam int SLOT_SIZE  = SLOT_BYTES_DEF;

  typedef struct packed {
    status_e             status;
    logic [BYTE_W-1:0]   out_byte;
    logic                out_last;
    logic [LEN_W-1:0]    pkt_len;
    logic                avail;
    logic [FILL_W-1:0]   fill;
  } fifo_result_t;

  class packet_fifo_scoreboard;
    logic [BYTE_W-1:0] slot_data [RING_SLOTS][SLOT_SIZE];
    logic [LEN_W-1:0]  slot_len  [RING_SLOTS];
    int                head_slot;
    int                tail_slot;
    int                fill;
    int                build_len;
    bit                build_trunc;
    bit                build_dropped;
    fifo_result_t      pending_results [$];
    int                errors;
    int                items_taken;
    int                stored_pkts;
    int                trunc_pkts;
    int                rejected_pkts;
    int                popped_pkts;
    int                popped_bytes;
    int                empty_pops;

    function new();
      head_slot     = 0;
      tail_slot     = 0;
      fill          = 0;
      build_len     = 0;
      build_trunc   = 0;
      build_dropped = 0;
      errors        = 0;
      items_taken   = 0;
      stored_pkts   = 0;
      trunc_pkts    = 0;
      rejected_pkts = 0;
      popped_pkts   = 0;
      popped_bytes  = 0;
      empty_pops    = 0;
    endfunction

    function void queue_result(status_e st, logic [BYTE_W-1:0] data, logic last, int len);
      fifo_result_t r;
      r.status   = st;
      r.out_byte = data;
      r.out_last = last;
      r.pkt_len  = LEN_W'(len);
      r.avail    = (fill > 0);
      r.fill     = FILL_W'(fill);
      pending_results.push_back(r);
    endfunction

    function void take_item(logic mode, logic [BYTE_W-1:0] data, logic last);
      int len;
      int slot;
      items_taken++;
      if (mode == MODE_POP) begin
        if (fill == 0) begin
          empty_pops++;
          queue_result(STAT_EMPTY, '0, 1'b1, 0);
        end else begin
          slot      = head_slot;
          len       = slot_len[slot];
          head_slot = (head_slot + 1) % RING_SLOTS;
          fill--;
          popped_pkts++;
          popped_bytes += len;
          for (int i = 0; i < len; i++)
            queue_result(STAT_POP_DATA, slot_data[slot][i], (i == len - 1), len);
        end
      end else begin
        // a packet that starts on a full ring is dropped as a whole
        if (build_len == 0 && !build_trunc && !build_dropped && fill >= RING_SLOTS)
          build_dropped = 1;
        if (!build_dropped) begin
          if (build_len < SLOT_SIZE) begin
            slot_data[tail_slot][build_len] = data;
            build_len++;
          end else begin
            build_trunc = 1;
          end
        end
        if (last) begin
          if (build_dropped) begin
            rejected_pkts++;
            queue_result(STAT_FULL, '0, 1'b1, 0);
          end else begin
            slot_len[tail_slot] = LEN_W'(build_len);
            tail_slot = (tail_slot + 1) % RING_SLOTS;
            fill++;
            stored_pkts++;
            if (build_trunc)
              trunc_pkts++;
            queue_result(build_trunc ? STAT_TRUNC : STAT_PUSHED, '0, 1'b1, build_len);
          end
          build_len     = 0;
          build_trunc   = 0;
          build_dropped = 0;
        end
      end
    endfunction

    function void check_result(fifo_result_t got);
      fifo_result_t exp;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d out_byte %0d", got.status, got.out_byte);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.out_byte !== exp.out_byte) begin
        $error("out_byte: expected %0d, actual %0d", exp.out_byte, got.out_byte);
        errors++;
      end
      if (got.out_last !== exp.out_last) begin
        $error("out_last: expected %0d, actual %0d", exp.out_last, got.out_last);
        errors++;
      end
      if (got.pkt_len !== exp.pkt_len) begin
        $error("packet_length: expected %0d, actual %0d", exp.pkt_len, got.pkt_len);
        errors++;
      end
      if (got.avail !== exp.avail) begin
        $error("available: expected %0d, actual %0d", exp.avail, got.avail);
        errors++;
      end
      if (got.fill !== exp.fill) begin
        $error("fill_count: expected %0d, actual %0d", exp.fill, got.fill);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// testbench of packet_slot_fifo_unit: directed and random push/pop streams
// with random stalls on both sides, every result checked against a predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  import psf_pkg::*;
  import psf_scoreboard_pkg::*;

  localparam int RANDOM_ITEMS   = 270;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // in_byte
  logic                 s_axis_tlast;   // in_last
  logic                 s_axis_tuser;   // mode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // out_byte, packet_length, available, fill_count, pad
  logic                 m_axis_tlast;   // out_last
  logic [STATUS_W-1:0]  m_axis_tuser;   // status

  packet_fifo_scoreboard sb;
  bit                    idle_on;
  int                    quiet_cycles;

  packet_slot_fifo_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: check accepted items, then pick next ready
  always @(posedge clk_i) begin
    fifo_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status   = status_e'(m_axis_tuser);
      got.out_byte = m_axis_tdata[7:0];
      got.pkt_len  = m_axis_tdata[14:8];
      got.avail    = m_axis_tdata[15];
      got.fill     = m_axis_tdata[20:16];
      got.out_last = m_axis_tlast;
      sb.check_result(got);
    end
    m_axis_tready <= !(idle_on && $urandom_range(99) < 9);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("timeout after %0d cycles without a handshake", WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(logic mode, logic [7:0] data, logic last);
    if (idle_on && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_item(mode, data, last);
  endtask

  task automatic pop_item();
    send_item(MODE_POP, 8'($urandom), 1'($urandom));
  endtask

  task automatic push_packet(int len, bit mid_pops);
    for (int i = 0; i < len; i++) begin
      send_item(MODE_PUSH, 8'($urandom), (i == len - 1));
      if (mid_pops && i != len - 1 && $urandom_range(99) < 8)
        pop_item();
    end
  endtask

  // fill the ring, then a packet that must be dropped even with a pop inside it
  task automatic fill_ring();
    int n;
    while (sb.fill < RING_SLOTS)
      push_packet($urandom_range(1, 3), 1'b0);
    n = $urandom_range(2, 4);
    for (int i = 0; i < n; i++) begin
      send_item(MODE_PUSH, 8'($urandom), (i == n - 1));
      if (i == 0)
        pop_item();
    end
  endtask

  initial begin
    int pick;
    sb            = new();
    idle_on       = 1'b1;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    s_axis_tuser  <= MODE_PUSH;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    pop_item();
    send_item(MODE_PUSH, 8'h00, 1'b1);
    send_item(MODE_PUSH, 8'hff, 1'b0);
    send_item(MODE_PUSH, 8'h80, 1'b0);
    send_item(MODE_PUSH, 8'h01, 1'b1);
    pop_item();
    send_item(MODE_PUSH, 8'haa, 1'b0);
    pop_item();
    send_item(MODE_PUSH, 8'h55, 1'b1);
    pop_item();
    pop_item();
    send_item(MODE_POP, 8'hff, 1'b1);

    // random
    for (int round = 0; sb.items_taken < RANDOM_ITEMS; round++) begin
      idle_on = !(sb.items_taken >= 140 && sb.items_taken < 200);
      pick    = $urandom_range(99);
      if (round == 0 || (round > 5 && pick < 4))
        fill_ring();
      else if (round == 2)
        push_packet(SLOT_SIZE + $urandom_range(1, 6), 1'b1);
      else if (round == 5)
        push_packet(SLOT_SIZE, 1'b0);
      else if (pick < 5)
        push_packet($urandom_range(SLOT_SIZE - 4, SLOT_SIZE + 4), 1'b1);
      else if (pick < 58)
        push_packet($urandom_range(1, 6), 1'b1);
      else
        pop_item();
    end
    idle_on = 1'b1;
    s_axis_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d items: %0d packets stored, %0d of them truncated, %0d dropped on a full ring",
             sb.items_taken, sb.stored_pkts, sb.trunc_pkts, sb.rejected_pkts);
    $display("%0d packets popped with %0d bytes, %0d pops on an empty ring",
             sb.popped_pkts, sb.popped_bytes, sb.empty_pops);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
